FILE: hw/rtl/trsm_pkg.sv
package trsm_pkg;

  localparam int TILE_HEIGHT   = 32;
  localparam int TILE_WIDTH    = 32;
  localparam int FACE_HEIGHT   = 16;
  localparam int FACE_WIDTH    = 16;
  localparam int PAGE_BITS     = 20;
  localparam int FACES_PER_ROW = TILE_WIDTH / FACE_WIDTH;
  localparam int FACE_SIZE     = FACE_HEIGHT * FACE_WIDTH;

  localparam int SIZE_W = 16;
  localparam int WORD_W = 32;
  localparam int OFS_W  = 10;
  localparam int CNT_W  = 11;
  localparam int TCNT_W = 12;

  typedef enum logic [1:0] {
    REG_IN_HEIGHT  = 2'd0,
    REG_IN_WIDTH   = 2'd1,
    REG_OUT_HEIGHT = 2'd2,
    REG_OUT_WIDTH  = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_M_OTC,
    S_D1_GO,
    S_D1_WAIT,
    S_D2_GO,
    S_D2_WAIT,
    S_M_A,
    S_M_B,
    S_M_C,
    S_M_D,
    S_D3_GO,
    S_D3_WAIT,
    S_D4_GO,
    S_D4_WAIT,
    S_M_E,
    S_M_F,
    S_M_G,
    S_M_H,
    S_CHECK,
    S_EMIT_OLD,
    S_UPDATE,
    S_EMIT_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [SIZE_W-1:0] eff(input logic [SIZE_W-1:0] v);
    return (v == '0) ? SIZE_W'(1) : v;
  endfunction

  function automatic logic [TCNT_W-1:0] tiles_h(input logic [SIZE_W-1:0] v);
    logic [SIZE_W:0] s;
    s = {1'b0, v} + (SIZE_W + 1)'(TILE_HEIGHT - 1);
    return TCNT_W'(s / TILE_HEIGHT);
  endfunction

  function automatic logic [TCNT_W-1:0] tiles_w(input logic [SIZE_W-1:0] v);
    logic [SIZE_W:0] s;
    s = {1'b0, v} + (SIZE_W + 1)'(TILE_WIDTH - 1);
    return TCNT_W'(s / TILE_WIDTH);
  endfunction

  function automatic logic [OFS_W-1:0] faced_offset(input logic [WORD_W-1:0] h,
                                                    input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] th, tw, face, off;
    th   = h % TILE_HEIGHT;
    tw   = w % TILE_WIDTH;
    face = (th / FACE_HEIGHT) * FACES_PER_ROW + tw / FACE_WIDTH;
    off  = face * FACE_SIZE + (th % FACE_HEIGHT) * FACE_WIDTH + tw % FACE_WIDTH;
    return off[OFS_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/trsm_div.sv
module trsm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [trsm_pkg::WORD_W-1:0] dividend,
  input  logic [trsm_pkg::WORD_W-1:0] divisor,
  output logic [trsm_pkg::WORD_W-1:0] quotient,
  output logic [trsm_pkg::WORD_W-1:0] remainder,
  output trsm_pkg::div_status_t       status
);
  import trsm_pkg::*;

  localparam int STEP_W = $clog2(WORD_W + 1);

  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;
  logic [WORD_W:0]   trial;
  logic              fits;

  assign trial = {rem, quo[WORD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(WORD_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one restoring step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[WORD_W-2:0], fits};
      rem <= fits ? WORD_W'(trial - {1'b0, dvs}) : trial[WORD_W-1:0];
    end
  end

  assign quotient    = quo;
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

endmodule

FILE: hw/rtl/tiled_reshape_segment_mapper_top.sv
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | output_page, tile_row, tile_col, page_end
// out     | out_valid | out_stall | src_page, src_offset, dst_offset, run_length,
//         |           |           | final_segment
// cfg     | cfg_en    | -         | cfg_index, cfg_data
// Each element passes through four divisions on the one shared radix-2 divider
// (start, 32 steps, done each), eight multiplies registered into prod and the states
// S_M_H, S_CHECK and S_UPDATE, plus S_EMIT_OLD and S_EMIT_FIN when it gives beats.
// in_stall is low only while the sequencer is idle; each element gives 0 to 2 beats.
// A waiting out beat holds the sequencer only when a new beat must be loaded; each
// stalled cycle then holds it in S_EMIT_OLD or S_EMIT_FIN.
// rst is synchronous; it clears the run and restores all size registers to 32.
module tiled_reshape_segment_mapper_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_en,
  input  logic [1:0]                     cfg_index,
  input  logic [trsm_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [trsm_pkg::PAGE_BITS-1:0] output_page,
  input  logic [4:0]                     tile_row,
  input  logic [4:0]                     tile_col,
  input  logic                           page_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [trsm_pkg::PAGE_BITS-1:0] src_page,
  output logic [trsm_pkg::OFS_W-1:0]     src_offset,
  output logic [trsm_pkg::OFS_W-1:0]     dst_offset,
  output logic [trsm_pkg::CNT_W-1:0]     run_length,
  output logic                           final_segment
);
  import trsm_pkg::*;

  logic [SIZE_W-1:0] in_height, in_width, out_height, out_width;
  logic [SIZE_W-1:0] ih, iw, oh, ow;
  logic [TCNT_W-1:0] oth, otw, ith, itw;

  state_t state, state_next;

  logic [PAGE_BITS-1:0] in_page;
  logic [4:0]           in_row, in_col;
  logic                 in_last;

  logic [WORD_W-1:0] prod, acc, co, hwt, ho, wo, ci, hw2, hi, wi;
  logic [PAGE_BITS-1:0] pg;
  logic [OFS_W-1:0]  ofs_i, ofs_o;
  logic              extend;

  logic                 run_open;
  logic [PAGE_BITS-1:0] run_page;
  logic [OFS_W-1:0]     run_src_start, run_dst_start, run_src_last, run_dst_last;
  logic [CNT_W-1:0]     run_count;

  logic [WORD_W-1:0] mul_a, mul_b, mul_p;
  logic              div_start;
  logic [WORD_W-1:0] div_a, div_b, div_q, div_r;
  div_status_t       div_st;
  logic              out_free, load_out, load_final;
  logic              accept;

  assign ih  = eff(in_height);
  assign iw  = eff(in_width);
  assign oh  = eff(out_height);
  assign ow  = eff(out_width);
  assign oth = tiles_h(oh);
  assign otw = tiles_w(ow);
  assign ith = tiles_h(ih);
  assign itw = tiles_w(iw);

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // pg and offsets are stable from S_CHECK on; run state changes only after S_UPDATE
  assign extend = run_open && (pg == run_page)
               && ({1'b0, ofs_i} == {1'b0, run_src_last} + 11'd1)
               && ({1'b0, ofs_o} == {1'b0, run_dst_last} + 11'd1);

  trsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .remainder(div_r),
    .status   (div_st)
  );

  assign mul_p = WORD_W'(mul_a * mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height  <= SIZE_W'(32);
      in_width   <= SIZE_W'(32);
      out_height <= SIZE_W'(32);
      out_width  <= SIZE_W'(32);
    end else if (cfg_en) begin
      case (cfg_index)
        REG_IN_HEIGHT:  in_height  <= cfg_data;
        REG_IN_WIDTH:   in_width   <= cfg_data;
        REG_OUT_HEIGHT: out_height <= cfg_data;
        REG_OUT_WIDTH:  out_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (accept) state_next = S_M_OTC;
      S_M_OTC:    state_next = S_D1_GO;
      S_D1_GO:    state_next = S_D1_WAIT;
      S_D1_WAIT:  if (div_st.done) state_next = S_D2_GO;
      S_D2_GO:    state_next = S_D2_WAIT;
      S_D2_WAIT:  if (div_st.done) state_next = S_M_A;
      S_M_A:      state_next = S_M_B;
      S_M_B:      state_next = S_M_C;
      S_M_C:      state_next = S_M_D;
      S_M_D:      state_next = S_D3_GO;
      S_D3_GO:    state_next = S_D3_WAIT;
      S_D3_WAIT:  if (div_st.done) state_next = S_D4_GO;
      S_D4_GO:    state_next = S_D4_WAIT;
      S_D4_WAIT:  if (div_st.done) state_next = S_M_E;
      S_M_E:      state_next = S_M_F;
      S_M_F:      state_next = S_M_G;
      S_M_G:      state_next = S_M_H;
      S_M_H:      state_next = S_CHECK;
      S_CHECK: begin
        if (!extend && run_open) state_next = S_EMIT_OLD;
        else state_next = S_UPDATE;
      end
      S_EMIT_OLD: if (out_free) state_next = S_UPDATE;
      S_UPDATE:   state_next = in_last ? S_EMIT_FIN : S_IDLE;
      S_EMIT_FIN: if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    div_start  = 1'b0;
    div_a      = acc;
    div_b      = prod;
    mul_a      = '0;
    mul_b      = '0;
    load_out   = 1'b0;
    load_final = 1'b0;
    case (state)
      S_IDLE:  in_stall = 1'b0;
      S_M_OTC: begin
        mul_a = WORD_W'(oth);
        mul_b = WORD_W'(otw);
      end
      S_D1_GO: begin
        div_start = 1'b1;
        div_a     = WORD_W'(in_page);
        div_b     = prod;
      end
      S_D2_GO: begin
        div_start = 1'b1;
        div_a     = hwt;
        div_b     = WORD_W'(otw);
      end
      S_M_A: begin
        mul_a = co;
        mul_b = WORD_W'(oh);
      end
      S_M_B: begin
        mul_a = prod;
        mul_b = WORD_W'(ow);
      end
      S_M_C: begin
        mul_a = ho;
        mul_b = WORD_W'(ow);
      end
      S_M_D: begin
        mul_a = WORD_W'(ih);
        mul_b = WORD_W'(iw);
      end
      S_D3_GO: begin
        div_start = 1'b1;
        div_a     = acc;
        div_b     = prod;
      end
      S_D4_GO: begin
        div_start = 1'b1;
        div_a     = hw2;
        div_b     = WORD_W'(iw);
      end
      S_M_E: begin
        mul_a = WORD_W'(ith);
        mul_b = WORD_W'(itw);
      end
      S_M_F: begin
        mul_a = ci;
        mul_b = prod;
      end
      S_M_G: begin
        mul_a = hi / TILE_HEIGHT;
        mul_b = WORD_W'(itw);
      end
      S_EMIT_OLD: load_out = out_free;
      S_EMIT_FIN: begin
        load_out   = out_free;
        load_final = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // datapath: the product is registered into prod; partial sums are built from prod into acc
  always_ff @(posedge clk) begin
    if (accept) begin
      in_page <= output_page;
      in_row  <= tile_row;
      in_col  <= tile_col;
      in_last <= page_end;
    end
    case (state)
      S_M_OTC, S_M_A, S_M_B, S_M_C, S_M_D, S_M_E, S_M_F, S_M_G: prod <= mul_p;
      default: ;
    endcase
    case (state)
      S_D1_WAIT: if (div_st.done) begin
        co  <= div_q;
        hwt <= div_r;
      end
      S_D2_WAIT: if (div_st.done) begin
        ho <= WORD_W'(div_q * TILE_HEIGHT) + WORD_W'(in_row);
        wo <= WORD_W'(div_r * TILE_WIDTH) + WORD_W'(in_col);
      end
      S_M_C:     acc <= prod;
      S_M_D:     acc <= acc + prod + wo;
      S_D3_WAIT: if (div_st.done) begin
        ci  <= div_q;
        hw2 <= div_r;
      end
      S_D4_WAIT: if (div_st.done) begin
        hi <= div_q;
        wi <= div_r;
      end
      S_M_G:     acc <= prod;
      S_M_H: begin
        pg    <= PAGE_BITS'(acc + prod + wi / TILE_WIDTH);
        ofs_i <= faced_offset(hi, wi);
        ofs_o <= faced_offset(ho, wo);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open      <= 1'b0;
      run_page      <= '0;
      run_src_start <= '0;
      run_dst_start <= '0;
      run_src_last  <= '0;
      run_dst_last  <= '0;
      run_count     <= '0;
    end else begin
      if (state == S_UPDATE) begin
        if (extend) begin
          run_count <= run_count + CNT_W'(1);
        end else begin
          run_open      <= 1'b1;
          run_page      <= pg;
          run_src_start <= ofs_i;
          run_dst_start <= ofs_o;
          run_count     <= CNT_W'(1);
        end
        run_src_last <= ofs_i;
        run_dst_last <= ofs_o;
      end
      // close the run once its final beat is loaded
      if (load_out && load_final) run_open <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      src_page      <= run_page;
      src_offset    <= run_src_start;
      dst_offset    <= run_dst_start;
      run_length    <= run_count;
      final_segment <= load_final;
    end
  end

  a_open_count: assert property (@(posedge clk) disable iff (rst)
    run_open |-> run_count != '0)
    else $error("open run with zero length");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_D1_WAIT || state == S_D2_WAIT ||
                     state == S_D3_WAIT || state == S_D4_WAIT))
    else $error("divider finished outside a wait state");

  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !div_st.busy)
    else $error("ready while divider busy");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("beat loaded over a waiting beat");

endmodule

FILE: sim/tiled_reshape_segment_mapper_checker.sv
module tiled_reshape_segment_mapper_checker
  import trsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_en,
  input  logic [1:0]            cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [PAGE_BITS-1:0]  output_page,
  input  logic [4:0]            tile_row,
  input  logic [4:0]            tile_col,
  input  logic                  page_end,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [PAGE_BITS-1:0]  src_page,
  input  logic [OFS_W-1:0]      src_offset,
  input  logic [OFS_W-1:0]      dst_offset,
  input  logic [CNT_W-1:0]      run_length,
  input  logic                  final_segment,
  output int                    fail_count,
  output int                    segs_pending
);

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [OFS_W-1:0]     src;
    logic [OFS_W-1:0]     dst;
    logic [CNT_W-1:0]     len;
    logic                 fin;
  } segment_t;

  segment_t seg_q[$];

  logic [SIZE_W-1:0] ih_reg, iw_reg, oh_reg, ow_reg;

  logic                 open_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [OFS_W-1:0]     src_start_q, dst_start_q, src_last_q, dst_last_q;
  logic [CNT_W-1:0]     count_q;

  function automatic longint unsigned nz(input logic [SIZE_W-1:0] v);
    return (v == 0) ? 64'd1 : 64'(v);
  endfunction

  // face-major offset inside a tile
  function automatic logic [OFS_W-1:0] tile_ofs(input longint unsigned h,
                                                input longint unsigned w);
    longint unsigned r, c, f;
    r = h % TILE_HEIGHT;
    c = w % TILE_WIDTH;
    f = (r / FACE_HEIGHT) * (TILE_WIDTH / FACE_WIDTH) + c / FACE_WIDTH;
    return OFS_W'(f * FACE_HEIGHT * FACE_WIDTH + (r % FACE_HEIGHT) * FACE_WIDTH
                  + c % FACE_WIDTH);
  endfunction

  task automatic map_element(input logic [PAGE_BITS-1:0] pg, input logic [4:0] row,
                             input logic [4:0] col, input logic last);
    longint unsigned ih, iw, oh, ow, otw, otc, co, hwt, ho, wo, flat, plane;
    longint unsigned ci, rem, hi, wi, itw, itc;
    logic [PAGE_BITS-1:0] pi;
    logic [OFS_W-1:0] oi, oo;
    segment_t s;
    ih = nz(ih_reg); iw = nz(iw_reg); oh = nz(oh_reg); ow = nz(ow_reg);
    otw = (ow + TILE_WIDTH - 1) / TILE_WIDTH;
    otc = ((oh + TILE_HEIGHT - 1) / TILE_HEIGHT) * otw;
    co = 64'(pg) / otc;
    hwt = 64'(pg) % otc;
    ho = (hwt / otw) * TILE_HEIGHT + row;
    wo = (hwt % otw) * TILE_WIDTH + col;
    oo = tile_ofs(ho, wo);
    flat = (co * oh * ow + ho * ow + wo) & 64'hFFFF_FFFF;
    plane = ih * iw;
    ci = flat / plane;
    rem = flat % plane;
    hi = rem / iw;
    wi = rem % iw;
    itw = (iw + TILE_WIDTH - 1) / TILE_WIDTH;
    itc = ((ih + TILE_HEIGHT - 1) / TILE_HEIGHT) * itw;
    pi = PAGE_BITS'(ci * itc + (hi / TILE_HEIGHT) * itw + wi / TILE_WIDTH);
    oi = tile_ofs(hi, wi);
    if (open_q && pi == page_q && {1'b0, oi} == {1'b0, src_last_q} + 1'b1 &&
        {1'b0, oo} == {1'b0, dst_last_q} + 1'b1) begin
      count_q = count_q + 1'b1;
    end else begin
      if (open_q) begin
        s = '{page_q, src_start_q, dst_start_q, count_q, 1'b0};
        seg_q = {seg_q, s};
      end
      open_q = 1'b1;
      page_q = pi;
      src_start_q = oi;
      dst_start_q = oo;
      count_q = 1;
    end
    src_last_q = oi;
    dst_last_q = oo;
    if (last) begin
      s = '{page_q, src_start_q, dst_start_q, count_q, 1'b1};
      seg_q = {seg_q, s};
      open_q = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    segment_t got, want;
    if (rst) begin
      ih_reg = 32; iw_reg = 32; oh_reg = 32; ow_reg = 32;
      open_q = 0; page_q = 0; src_start_q = 0; dst_start_q = 0;
      src_last_q = 0; dst_last_q = 0; count_q = 0;
      seg_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{src_page, src_offset, dst_offset, run_length, final_segment};
        if (seg_q.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: unexpected segment beat, expected none, got %h", $time, got);
        end else begin
          want = seg_q.pop_front();
          if (got.page !== want.page)
            $display("%0t: src_page expected %h got %h", $time, want.page, got.page);
          if (got.src !== want.src)
            $display("%0t: src_offset expected %h got %h", $time, want.src, got.src);
          if (got.dst !== want.dst)
            $display("%0t: dst_offset expected %h got %h", $time, want.dst, got.dst);
          if (got.len !== want.len)
            $display("%0t: run_length expected %h got %h", $time, want.len, got.len);
          if (got.fin !== want.fin)
            $display("%0t: final_segment expected %h got %h", $time, want.fin, got.fin);
          if (got !== want) fail_count = fail_count + 1;
        end
      end
      if (in_valid && !in_stall) map_element(output_page, tile_row, tile_col, page_end);
      if (cfg_en) begin
        case (reg_idx_t'(cfg_index))
          REG_IN_HEIGHT:  ih_reg = cfg_data;
          REG_IN_WIDTH:   iw_reg = cfg_data;
          REG_OUT_HEIGHT: oh_reg = cfg_data;
          REG_OUT_WIDTH:  ow_reg = cfg_data;
          default: ;
        endcase
      end
    end
    segs_pending = seg_q.size();
  end

  initial begin
    fail_count = 0;
    segs_pending = 0;
  end

endmodule

FILE: sim/tiled_reshape_segment_mapper_top_tb.sv
module tiled_reshape_segment_mapper_top_tb;
  import trsm_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_en = 0;
  logic [1:0]           cfg_index = 0;
  logic [SIZE_W-1:0]    cfg_data = 0;
  logic                 in_valid = 0;
  logic                 in_stall;
  logic [PAGE_BITS-1:0] output_page = 0;
  logic [4:0]           tile_row = 0;
  logic [4:0]           tile_col = 0;
  logic                 page_end = 0;
  logic                 out_valid;
  logic                 out_stall = 0;
  logic [PAGE_BITS-1:0] src_page;
  logic [OFS_W-1:0]     src_offset, dst_offset;
  logic [CNT_W-1:0]     run_length;
  logic                 final_segment;
  int                   fail_count, segs_pending;
  int                   cycles = 0;
  int                   send_idle = 0, recv_idle = 0;

  always #10 clk = ~clk;

  tiled_reshape_segment_mapper_top u_top (.*);
  tiled_reshape_segment_mapper_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < recv_idle);

  task automatic set_mode(input int m);
    case (m % 4)
      0: begin send_idle = 0; recv_idle = 0; end
      1: begin send_idle = 53; recv_idle = 0; end
      2: begin send_idle = 0; recv_idle = 53; end
      default: begin send_idle = 6; recv_idle = 6; end
    endcase
  endtask

  task automatic send_element(input logic [PAGE_BITS-1:0] pg, input logic [4:0] row,
                              input logic [4:0] col, input logic last);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    output_page <= pg;
    tile_row <= row;
    tile_col <= col;
    page_end <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk) in_valid <= 0;
    while (segs_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_sizes(input logic [SIZE_W-1:0] ih, input logic [SIZE_W-1:0] iw,
                             input logic [SIZE_W-1:0] oh, input logic [SIZE_W-1:0] ow);
    cfg_en <= 1; cfg_index <= REG_IN_HEIGHT;  cfg_data <= ih; @(negedge clk);
    cfg_index <= REG_IN_WIDTH;   cfg_data <= iw; @(negedge clk);
    cfg_index <= REG_OUT_HEIGHT; cfg_data <= oh; @(negedge clk);
    cfg_index <= REG_OUT_WIDTH;  cfg_data <= ow; @(negedge clk);
    cfg_en <= 0;
    @(negedge clk);
  endtask

  // mostly walks of consecutive columns ending in page_end, some stray elements
  task automatic random_traffic(input int n);
    int done_n, len;
    logic [PAGE_BITS-1:0] pg;
    logic [4:0] r, c;
    done_n = 0;
    while (done_n < n) begin
      if ($urandom_range(0, 99) < 15) begin
        send_element(PAGE_BITS'($urandom), 5'($urandom), 5'($urandom),
                     $urandom_range(0, 3) == 0);
        done_n++;
      end else begin
        pg = ($urandom_range(0, 3) == 0) ? PAGE_BITS'($urandom)
                                         : PAGE_BITS'($urandom_range(0, 40));
        r = 5'($urandom); c = 5'($urandom);
        len = $urandom_range(1, 40);
        for (int k = 0; k < len; k++) begin
          send_element(pg, r, c, k == len - 1 || $urandom_range(0, 99) == 0);
          c = c + 1'b1;
          if (c == 0) r = r + 1'b1;
        end
        done_n += len;
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    set_mode(0);
    // directed: field extremes and run merge, break and flush cases
    send_element('0, 5'd0, 5'd0, 1'b1);
    send_element('1, 5'd31, 5'd31, 1'b1);
    send_element('0, 5'd0, 5'd14, 1'b0);
    send_element('0, 5'd0, 5'd15, 1'b0);
    send_element('0, 5'd0, 5'd16, 1'b0);
    send_element('0, 5'd0, 5'd17, 1'b1);
    send_element(20'd3, 5'd7, 5'd1, 1'b0);
    send_element(20'd3, 5'd7, 5'd2, 1'b0);
    send_element(20'd9, 5'd7, 5'd3, 1'b0);
    send_element(20'd9, 5'd7, 5'd9, 1'b1);
    send_element(20'hAAAAA, 5'd21, 5'd10, 1'b0);
    send_element(20'h55555, 5'd10, 5'd21, 1'b1);
    send_element(20'd1, 5'd31, 5'd0, 1'b0);
    send_element(20'd1, 5'd31, 5'd1, 1'b1);
    send_element(20'd2, 5'd16, 5'd16, 1'b1);
    settle();
    write_sizes(0, 0, 0, 0);
    send_element(20'd0, 5'd31, 5'd31, 1'b1);
    send_element('1, 5'd0, 5'd0, 1'b1);
    settle();
    write_sizes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_element('1, 5'd31, 5'd31, 1'b0);
    send_element(20'd0, 5'd0, 5'd0, 1'b1);
    settle();
    for (int ph = 0; ph < 7; ph++) begin
      set_mode(ph);
      case (ph)
        0: write_sizes(32, 32, 32, 32);
        1: write_sizes(0, 0, 0, 0);
        2: write_sizes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: write_sizes(16, 64, 32, 32);
        4: write_sizes(48, 40, 100, 7);
        5: write_sizes(1, 16'hFFFF, 3, 1000);
        default: write_sizes(SIZE_W'($urandom), SIZE_W'($urandom),
                             SIZE_W'($urandom_range(1, 200)),
                             SIZE_W'($urandom_range(1, 200)));
      endcase
      random_traffic(65);
      settle();
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: tiled_reshape_segment_mapper_top.f
hw/rtl/trsm_pkg.sv
hw/rtl/trsm_div.sv
hw/rtl/tiled_reshape_segment_mapper_top.sv
sim/tiled_reshape_segment_mapper_checker.sv
sim/tiled_reshape_segment_mapper_top_tb.sv
